### rtl/erm_pkg.sv
package erm_pkg;

    localparam int TABLE_ENTRIES = 361;
    localparam int DEGREES       = 360;
    localparam int HALF_TURN     = 180;
    localparam int QUARTER_TURN  = 90;
    localparam int ADDR_W        = 9;
    localparam int ANGLE_W       = 32;

    // pi / 180 in Q60
    localparam longint unsigned DEG_Q60 = 64'h3243F6A8885A308D / 64'd180;

    typedef logic signed [31:0] t_rom [0:TABLE_ENTRIES-1];

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // write strobe from the trig unit into the angle bank
    typedef struct packed {
        logic  valid;
        t_axis axis;
    } t_trig_wr;

    // first quadrant sine, Taylor series in Q30, rounded to fb fraction bits
    function automatic int quad_sin(input int k, input int fb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (longint'(k) * DEG_Q60) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
        return int'((longint'(sum) + (longint'(1) << (29 - fb))) >> (30 - fb));
    endfunction

    // whole circle by quadrant symmetry
    function automatic int sin_deg(input int d, input int fb);
        int r;
        if (d <= QUARTER_TURN) begin
            r = quad_sin(d, fb);
        end else if (d <= HALF_TURN) begin
            r = quad_sin(HALF_TURN - d, fb);
        end else if (d <= HALF_TURN + QUARTER_TURN) begin
            r = -quad_sin(d - HALF_TURN, fb);
        end else begin
            r = -quad_sin(DEGREES - d, fb);
        end
        return r;
    endfunction

    function automatic t_rom build_rom(input int fb, input bit cosine);
        t_rom t;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (cosine) begin
                t[k] = sin_deg((k + QUARTER_TURN) % DEGREES, fb);
            end else begin
                t[k] = sin_deg(k % DEGREES, fb);
            end
        end
        return t;
    endfunction

endpackage

### rtl/erm_trig.sv
module erm_trig
    import erm_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ANGLE_W-1:0]            i_angle_x,
    input  logic [ANGLE_W-1:0]            i_angle_y,
    input  logic [ANGLE_W-1:0]            i_angle_z,
    output t_trig_wr                      o_wr,
    output logic signed [FRACTION_BITS+1:0] o_cos,
    output logic signed [FRACTION_BITS+1:0] o_sin
);

    localparam int W    = FRACTION_BITS + 2;
    localparam int U_W  = ANGLE_W - FRACTION_BITS + 1;
    localparam int S    = U_W + 9;
    localparam int M_W  = S - 7;
    localparam int Q_W  = U_W - 8;
    localparam int P_W  = U_W + M_W;
    localparam int PI_W = FRACTION_BITS + W + 2;
    localparam longint unsigned RECIP = ((64'd1 << S) + DEGREES - 1) / DEGREES;
    localparam longint unsigned OFFSET =
        DEGREES * ((2 ** (ANGLE_W - 1 - FRACTION_BITS) + DEGREES - 1) / DEGREES);
    localparam t_rom SIN_TAB = build_rom(FRACTION_BITS, 1'b0);
    localparam t_rom COS_TAB = build_rom(FRACTION_BITS, 1'b1);

    logic [ANGLE_W-1:0]       r_ang [3];
    logic                     r_act;
    t_axis                    r_axis;
    logic [ANGLE_W-1:0]       n_ang;

    logic                     r1_v, r2_v, r3_v, r4_v, r5_v;
    t_axis                    r1_ax, r2_ax, r3_ax, r4_ax, r5_ax;
    logic [U_W-1:0]           r1_u, r2_u;
    logic [FRACTION_BITS-1:0] r1_f, r2_f, r3_f, r4_f;
    logic [Q_W-1:0]           r2_q;
    logic [ADDR_W-1:0]        r3_idx;
    logic signed [W-1:0]      r4_c0, r4_c1, r4_s0, r4_s1;
    logic signed [W-1:0]      r5_cb, r5_sb;
    logic signed [PI_W-1:0]   r5_cp, r5_sp;

    logic [P_W-1:0]           n_prod;
    logic [U_W-1:0]           n_deg;
    logic signed [W:0]        n_dc, n_ds;
    logic signed [PI_W-1:0]   n_fx;

    // sequencer: three angles one after another
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_axis <= AXIS_X;
        end else if (i_start) begin
            r_act  <= 1'b1;
            r_axis <= AXIS_X;
        end else if (r_act) begin
            unique case (r_axis)
                AXIS_X:  r_axis <= AXIS_Y;
                AXIS_Y:  r_axis <= AXIS_Z;
                default: r_act  <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ang[0] <= i_angle_x;
            r_ang[1] <= i_angle_y;
            r_ang[2] <= i_angle_z;
        end
    end

    always_comb begin
        unique case (r_axis)
            AXIS_X:  n_ang = r_ang[0];
            AXIS_Y:  n_ang = r_ang[1];
            default: n_ang = r_ang[2];
        endcase
    end

    // whole degrees offset to non-negative, fraction split off
    always_ff @(posedge i_clk) begin
        r1_u <= U_W'($signed(n_ang[ANGLE_W-1:FRACTION_BITS])) + U_W'(OFFSET);
        r1_f <= n_ang[FRACTION_BITS-1:0];
    end

    // quotient by 360 through reciprocal
    assign n_prod = P_W'(r1_u) * P_W'(RECIP);
    always_ff @(posedge i_clk) begin
        r2_q <= n_prod[S +: Q_W];
        r2_u <= r1_u;
        r2_f <= r1_f;
    end

    // remainder gives the table index
    assign n_deg = r2_u - U_W'(r2_q) * U_W'(DEGREES);
    always_ff @(posedge i_clk) begin
        r3_idx <= n_deg[ADDR_W-1:0];
        r3_f   <= r2_f;
    end

    // table read, two neighbouring entries of each
    always_ff @(posedge i_clk) begin
        r4_c0 <= COS_TAB[r3_idx][W-1:0];
        r4_c1 <= COS_TAB[r3_idx + ADDR_W'(1)][W-1:0];
        r4_s0 <= SIN_TAB[r3_idx][W-1:0];
        r4_s1 <= SIN_TAB[r3_idx + ADDR_W'(1)][W-1:0];
        r4_f  <= r3_f;
    end

    // interpolation products
    assign n_dc = (W+1)'(r4_c1) - (W+1)'(r4_c0);
    assign n_ds = (W+1)'(r4_s1) - (W+1)'(r4_s0);
    assign n_fx = PI_W'($signed({1'b0, r4_f}));
    always_ff @(posedge i_clk) begin
        r5_cp <= n_fx * PI_W'(n_dc);
        r5_sp <= n_fx * PI_W'(n_ds);
        r5_cb <= r4_c0;
        r5_sb <= r4_s0;
    end

    // floor and add to the base entry
    always_ff @(posedge i_clk) begin
        o_cos <= r5_cb + W'(r5_cp >>> FRACTION_BITS);
        o_sin <= r5_sb + W'(r5_sp >>> FRACTION_BITS);
    end

    // valid and axis tags along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
            r4_v <= 1'b0; r5_v <= 1'b0; o_wr.valid <= 1'b0;
        end else begin
            r1_v <= r_act; r2_v <= r1_v; r3_v <= r2_v;
            r4_v <= r3_v;  r5_v <= r4_v; o_wr.valid <= r5_v;
        end
        o_wr.axis <= r5_ax;
    end

    always_ff @(posedge i_clk) begin
        r1_ax <= r_axis; r2_ax <= r1_ax; r3_ax <= r2_ax;
        r4_ax <= r3_ax;  r5_ax <= r4_ax;
    end

endmodule

### rtl/euler_rotation_matrix.sv
// a request passes the input buffer, the trig pipe and the angle bank to the element bank,
// which issues one element a cycle while the result channel does not stall; the request
// rate is set by that one-element channel, and the trig pipe overlaps the previous request's elements
// reset clears the handshake and sequencing state; the sine and cosine tables are constant
module euler_rotation_matrix
    import erm_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [ANGLE_W-1:0]       i_angle_x,
    input  logic signed [ANGLE_W-1:0]       i_angle_y,
    input  logic signed [ANGLE_W-1:0]       i_angle_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_row_index,
    output logic [1:0]                      o_col_index,
    output logic signed [FRACTION_BITS+1:0] o_element_value,
    output logic                            o_last_element
);

    localparam int W  = FRACTION_BITS + 2;
    localparam int PW = 2 * W;
    localparam logic signed [W-1:0] ONE = {2'b01, {FRACTION_BITS{1'b0}}};
    localparam logic [1:0] LAST_IDX = 2'd3;
    localparam logic [1:0] COL_SIN  = 2'd1;
    localparam logic [1:0] COL_COS  = 2'd0;
    localparam logic [1:0] COL_PASS = 2'd2;
    localparam logic [1:0] ROW_X    = 2'd0;
    localparam logic [1:0] ROW_C    = 2'd1;
    localparam logic [1:0] ROW_S    = 2'd2;

    logic                   r_in_valid;
    logic [ANGLE_W-1:0]     r_ax, r_ay, r_az;
    logic                   r_busy;
    logic                   n_start;
    t_trig_wr               trig_wr;
    logic signed [W-1:0]    trig_cos, trig_sin;

    logic signed [W-1:0]    r_tb_c [3];
    logic signed [W-1:0]    r_tb_s [3];
    logic                   r_tb_full;
    logic signed [W-1:0]    r_eb_c [3];
    logic signed [W-1:0]    r_eb_s [3];
    logic                   r_eb_valid;
    logic                   n_load;
    logic [3:0]             r_cnt;

    logic                   n_adv, n_issue;
    logic [1:0]             n_row, n_col;
    logic signed [W-1:0]    n_a, n_b, n_t1, n_k1, n_k2;

    logic                   r0_v, r1_v, r2_v;
    logic [1:0]             r0_row, r0_col, r1_row, r1_col, r2_row, r2_col;
    logic                   r0_last, r1_last, r2_last;
    logic signed [W-1:0]    r0_a, r0_b, r0_t1, r0_k1, r0_k2;
    logic signed [W-1:0]    r1_t1, r1_k1, r1_k2;
    logic signed [PW-1:0]   r1_p;
    logic signed [W-1:0]    n_t;
    logic signed [PW-1:0]   r2_p1, r2_p2;
    logic signed [PW:0]     n_sum;
    logic signed [PW:0]     n_fl;

    // input request buffer
    assign o_ready = !r_in_valid;
    assign n_start = r_in_valid && !r_busy && !r_tb_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (n_start) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ax <= i_angle_x;
            r_ay <= i_angle_y;
            r_az <= i_angle_z;
        end
    end

    erm_trig #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_trig (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_start),
        .i_angle_x(r_ax),
        .i_angle_y(r_ay),
        .i_angle_z(r_az),
        .o_wr     (trig_wr),
        .o_cos    (trig_cos),
        .o_sin    (trig_sin)
    );

    // angle bank filled by the trig unit, handed to the element bank
    // as the last element of the previous matrix issues, or at once when the element bank is empty
    assign n_load = r_tb_full && (!r_eb_valid || (n_issue && r_cnt == 4'hF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_tb_full <= 1'b0;
        end else begin
            if (n_start) begin
                r_busy <= 1'b1;
            end else if (trig_wr.valid && trig_wr.axis == AXIS_Z) begin
                r_busy <= 1'b0;
            end
            if (trig_wr.valid && trig_wr.axis == AXIS_Z) begin
                r_tb_full <= 1'b1;
            end else if (n_load) begin
                r_tb_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (trig_wr.valid) begin
            unique case (trig_wr.axis)
                AXIS_X: begin r_tb_c[0] <= trig_cos; r_tb_s[0] <= trig_sin; end
                AXIS_Y: begin r_tb_c[1] <= trig_cos; r_tb_s[1] <= trig_sin; end
                default: begin r_tb_c[2] <= trig_cos; r_tb_s[2] <= trig_sin; end
            endcase
        end
        if (n_load) begin
            r_eb_c <= r_tb_c;
            r_eb_s <= r_tb_s;
        end
    end

    // element sequencer
    assign n_adv   = !o_valid || i_ready;
    assign n_issue = n_adv && r_eb_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eb_valid <= 1'b0;
            r_cnt      <= '0;
        end else if (n_load) begin
            r_eb_valid <= 1'b1;
            r_cnt      <= '0;
        end else if (n_issue) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'hF) begin
                r_eb_valid <= 1'b0;
            end
        end
    end

    // operand selection: T = a*b is the Rx*Ry term, then T*k1 + t1*k2
    assign n_row = r_cnt[3:2];
    assign n_col = r_cnt[1:0];

    always_comb begin
        n_a  = '0;
        n_b  = ONE;
        n_t1 = '0;
        if (n_col == LAST_IDX) begin
            n_a = (n_row == LAST_IDX) ? ONE : '0;
        end else begin
            unique case (n_row)
                ROW_X: begin
                    n_a = ONE;
                    n_b = (n_col == COL_PASS) ? -r_eb_s[1] : r_eb_c[1];
                end
                ROW_C: begin
                    n_a  = r_eb_s[0];
                    n_b  = (n_col == COL_PASS) ? r_eb_c[1] : r_eb_s[1];
                    n_t1 = r_eb_c[0];
                end
                ROW_S: begin
                    n_a  = r_eb_c[0];
                    n_b  = (n_col == COL_PASS) ? r_eb_c[1] : r_eb_s[1];
                    n_t1 = -r_eb_s[0];
                end
                default: begin
                    n_a = '0;
                end
            endcase
        end
        unique case (n_col)
            COL_COS: begin n_k1 = r_eb_c[2]; n_k2 = -r_eb_s[2]; end
            COL_SIN: begin n_k1 = r_eb_s[2]; n_k2 = r_eb_c[2];  end
            default: begin n_k1 = ONE;       n_k2 = '0;         end
        endcase
    end

    // element pipe, stalls as a whole on the result channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (n_adv) begin
            r0_v    <= n_issue;
            r1_v    <= r0_v;
            r2_v    <= r1_v;
            o_valid <= r2_v;
        end
    end

    assign n_t   = W'(r1_p >>> FRACTION_BITS);
    assign n_sum = (PW+1)'(r2_p1) + (PW+1)'(r2_p2);
    assign n_fl  = n_sum >>> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r0_row  <= n_row;
            r0_col  <= n_col;
            r0_last <= (r_cnt == 4'hF);
            r0_a    <= n_a;
            r0_b    <= n_b;
            r0_t1   <= n_t1;
            r0_k1   <= n_k1;
            r0_k2   <= n_k2;

            r1_p    <= PW'(r0_a) * PW'(r0_b);
            r1_t1   <= r0_t1;
            r1_k1   <= r0_k1;
            r1_k2   <= r0_k2;
            r1_row  <= r0_row;
            r1_col  <= r0_col;
            r1_last <= r0_last;

            r2_p1   <= PW'(n_t) * PW'(r1_k1);
            r2_p2   <= PW'(r1_t1) * PW'(r1_k2);
            r2_row  <= r1_row;
            r2_col  <= r1_col;
            r2_last <= r1_last;

            // floor then clamp to plus or minus one
            if (n_fl > (PW+1)'(ONE)) begin
                o_element_value <= ONE;
            end else if (n_fl < -(PW+1)'(ONE)) begin
                o_element_value <= -ONE;
            end else begin
                o_element_value <= n_fl[W-1:0];
            end
            o_row_index    <= r2_row;
            o_col_index    <= r2_col;
            o_last_element <= r2_last;
        end
    end

    a_last_is_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_element |-> o_row_index == LAST_IDX && o_col_index == LAST_IDX)
        else $error("last element flagged away from the corner");

    a_no_bank_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig_wr.valid |-> !r_tb_full)
        else $error("trig write into a full angle bank");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_start |=> r_busy && !r_tb_full)
        else $error("trig unit started while busy");

    a_load_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load |=> r_cnt == 4'd0 && r_eb_valid)
        else $error("element bank loaded with a stale counter");

endmodule

### test/euler_rotation_matrix_checker.sv
`timescale 1ns / 1ps

module euler_rotation_matrix_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_angle_x,
    input  logic signed [31:0] i_angle_y,
    input  logic signed [31:0] i_angle_z,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_row_index,
    input  logic [1:0]         i_col_index,
    input  logic signed [17:0] i_element_value,
    input  logic               i_last_element,
    output int                 o_errors,
    output int                 o_pending
);
    localparam int FB = 16;

    typedef struct packed {
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [17:0] value;
        logic               last;
    } t_element;

    t_element    expected_elements[$];
    longint      cos_table[0:360];
    longint      sin_table[0:360];
    longint      deg_q60;

    // first quadrant sine in Q30, rounded to FB bits
    function automatic longint quadrant_sine(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (64'(k) * deg_q60) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
        return (acc + (64'sd1 << (29 - FB))) >>> (30 - FB);
    endfunction

    function automatic longint circle_sine(input int d);
        if (d <= 90) return quadrant_sine(d);
        if (d <= 180) return quadrant_sine(180 - d);
        if (d <= 270) return -quadrant_sine(d - 180);
        return -quadrant_sine(360 - d);
    endfunction

    // floor division by 2^FB
    function automatic longint floor_fb(input longint v);
        return v >>> FB;
    endfunction

    function automatic longint interp(input bit use_cos, input logic signed [31:0] a);
        longint period;
        longint r;
        longint i;
        longint f;
        longint t0;
        longint t1;
        period = 360 * (64'sd1 << FB);
        r = longint'(a) % period;
        if (r < 0) r += period;
        i = r >>> FB;
        f = r & ((64'sd1 << FB) - 1);
        t0 = use_cos ? cos_table[i] : sin_table[i];
        t1 = use_cos ? cos_table[i + 1] : sin_table[i + 1];
        return t0 + floor_fb(f * (t1 - t0));
    endfunction

    // builds Rx*Ry*Rz and queues the sixteen elements
    task automatic predict_rotation(input logic signed [31:0] ax, ay, az);
        longint mx[4][4];
        longint my[4][4];
        longint mz[4][4];
        longint mt[4][4];
        longint acc;
        longint one;
        longint c;
        longint s;
        t_element e;
        one = 64'sd1 << FB;
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++) begin
                mx[r][k] = 0; my[r][k] = 0; mz[r][k] = 0;
            end
        c = interp(1, ax); s = interp(0, ax);
        mx[0][0] = one; mx[1][1] = c; mx[1][2] = s; mx[2][1] = -s; mx[2][2] = c;
        mx[3][3] = one;
        c = interp(1, ay); s = interp(0, ay);
        my[0][0] = c; my[0][2] = -s; my[1][1] = one; my[2][0] = s; my[2][2] = c;
        my[3][3] = one;
        c = interp(1, az); s = interp(0, az);
        mz[0][0] = c; mz[0][1] = s; mz[1][0] = -s; mz[1][1] = c; mz[2][2] = one;
        mz[3][3] = one;
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++) begin
                acc = 0;
                for (int j = 0; j < 4; j++) acc += mx[r][j] * my[j][k];
                mt[r][k] = floor_fb(acc);
            end
        for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++) begin
                acc = 0;
                for (int j = 0; j < 4; j++) acc += mt[r][j] * mz[j][k];
                acc = floor_fb(acc);
                if (acc > one) acc = one;
                if (acc < -one) acc = -one;
                e.row   = 2'(r);
                e.col   = 2'(k);
                e.value = 18'(acc);
                e.last  = (r == 3 && k == 3);
                expected_elements.push_back(e);
            end
    endtask

    initial begin
        deg_q60 = 64'h3243F6A8885A308D / 64'd180;
        for (int k = 0; k <= 360; k++) begin
            sin_table[k] = circle_sine(k % 360);
            cos_table[k] = circle_sine((k + 90) % 360);
        end
        o_errors = 0;
    end

    assign o_pending = expected_elements.size();

    // predict on each request, compare on each element
    always @(posedge i_clk) begin
        t_element got;
        t_element want;
        if (i_rst_n) begin
            if (i_valid && i_in_ready) predict_rotation(i_angle_x, i_angle_y, i_angle_z);
            if (i_out_valid && i_out_ready) begin
                got = {i_row_index, i_col_index, i_element_value, i_last_element};
                if (expected_elements.size() == 0) begin
                    $display("%0t: unexpected element, expected none, actual %h", $time, got);
                    o_errors++;
                end else begin
                    want = expected_elements.pop_front();
                    if (got.row != want.row || got.col != want.col) begin
                        $display("%0t: index mismatch, expected %0d,%0d actual %0d,%0d", $time,
                                 want.row, want.col, got.row, got.col);
                        o_errors++;
                    end
                    if (got.value != want.value) begin
                        $display("%0t: element mismatch at %0d,%0d, expected %0d actual %0d",
                                 $time, want.row, want.col, want.value, got.value);
                        o_errors++;
                    end
                    if (got.last != want.last) begin
                        $display("%0t: last flag mismatch, expected %0b actual %0b", $time,
                                 want.last, got.last);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

### test/euler_rotation_matrix_tb.sv
`timescale 1ns / 1ps

module euler_rotation_matrix_tb;
    localparam int ONE_DEG = 65536;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [31:0] angle_x = 0;
    logic signed [31:0] angle_y = 0;
    logic signed [31:0] angle_z = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [17:0] element_value;
    logic               last_element;
    int                 errors;
    int                 pending;
    int                 idle_cycles = 0;
    int                 hold_left = 0;
    bit                 calm_phase = 0;
    bit                 long_hold = 0;

    always #5 i_clk = ~i_clk;

    euler_rotation_matrix dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_angle_x(angle_x), .i_angle_y(angle_y), .i_angle_z(angle_z),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_row_index(row_index), .o_col_index(col_index),
        .o_element_value(element_value), .o_last_element(last_element)
    );

    euler_rotation_matrix_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_angle_x(angle_x), .i_angle_y(angle_y), .i_angle_z(angle_z),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_row_index(row_index), .i_col_index(col_index),
        .i_element_value(element_value), .i_last_element(last_element),
        .o_errors(errors), .o_pending(pending)
    );

    // one request, waits for acceptance; valid stays up for a following request
    task automatic send_angles(input logic signed [31:0] ax, ay, az);
        angle_x  <= ax;
        angle_y  <= ay;
        angle_z  <= az;
        in_valid <= 1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic random_gap();
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] random_angle();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 360) * ONE_DEG;
            2: return -($urandom_range(0, 720) * ONE_DEG);
            3: return 32'($urandom_range(0, 90 * ONE_DEG));
            default: return 32'($urandom_range(0, 720 * ONE_DEG)) - 360 * ONE_DEG;
        endcase
    endfunction

    // receiver stalls in random bursts, with one long hold-off at the start
    always @(posedge i_clk) begin
        if (long_hold) begin
            out_ready <= 0;
        end else if (hold_left > 0) begin
            out_ready <= 0;
            hold_left <= hold_left - 1;
        end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            out_ready <= 0;
            hold_left <= $urandom_range(0, 3);
        end else begin
            out_ready <= 1;
        end
    end

    initial begin
        long_hold = 1;
        repeat (300) @(posedge i_clk);
        long_hold = 0;
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] corner[] = '{0, 32'sh7FFFFFFF, 32'sh80000000, 90 * ONE_DEG,
            -90 * ONE_DEG, 720 * ONE_DEG, 180 * ONE_DEG, 270 * ONE_DEG, 359 * ONE_DEG + 65535,
            45 * ONE_DEG + 32768, -1, 1};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // corner angles, each on every axis
        send_angles(0, 0, 0);
        foreach (corner[k]) begin
            send_angles(corner[k], 0, 0);
            send_angles(0, corner[k], corner[(k + 3) % corner.size()]);
        end
        // sender pause until all elements drained
        in_valid <= 0;
        @(posedge i_clk);
        wait (pending == 0);
        for (int n = 0; n < 330; n++) begin
            if (n == 280) calm_phase = 1;
            send_angles(random_angle(), random_angle(), random_angle());
            random_gap();
        end
        in_valid <= 0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
